>>> hdl/sol_pkg.sv
package sol_pkg;

    localparam int SESSION_DEPTH = 1024;
    localparam int NAME_CHARS = 8;

    localparam int IDX_W = (SESSION_DEPTH > 1) ? $clog2(SESSION_DEPTH) : 1;
    localparam int CNT_W = $clog2(SESSION_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W = 224;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 72;

    localparam logic [63:0] NAME_MASK = (NAME_CHARS >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * NAME_CHARS)) - 64'd1);

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] STAT_DONE = 3'd0;
    localparam logic [2:0] STAT_FULL = 3'd1;
    localparam logic [2:0] STAT_EXACT = 3'd2;
    localparam logic [2:0] STAT_GUESS = 3'd3;
    localparam logic [2:0] STAT_NONE = 3'd4;

    typedef struct packed {
        logic [31:0] uid;
        logic [63:0] name;
        logic [31:0] tty;
        logic [31:0] start;
        logic [31:0] fin;
    } sess_entry_t;

    typedef struct packed {
        logic [1:0]  req;
        sess_entry_t entry;
    } cmd_t;

endpackage

>>> hdl/sol_front.sv
module sol_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sol_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [sol_pkg::IN_USER_W-1:0] s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sol_pkg::cmd_t                 push_data
);
    import sol_pkg::*;

    logic [31:0] when;
    logic [33:0] sum;

    assign when = s_tdata[159:128];
    assign sum  = {2'b00, when} + {2'b00, s_tdata[191:160]} + {2'b00, s_tdata[223:192]};

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb
    begin
        push_data.req         = s_tuser;
        push_data.entry.uid   = s_tdata[31:0];
        push_data.entry.name  = s_tdata[95:32] & NAME_MASK;
        push_data.entry.tty   = s_tdata[127:96];
        push_data.entry.start = when;
        push_data.entry.fin   = (sum[33:32] != 2'b00) ? {32{1'b1}} : sum[31:0];
    end

endmodule

>>> hdl/sol_cmd_queue.sv
module sol_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sol_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sol_pkg::cmd_t pop_data
);
    import sol_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/sol_back.sv
module sol_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  sol_pkg::cmd_t                  pop_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sol_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sol_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    sess_entry_t mem [SESSION_DEPTH];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic               have_reg, have_next;
    logic               res_valid_reg, res_valid_next;
    logic [31:0]        latest_reg, latest_next;
    logic [63:0]        guess_reg, guess_next;
    logic [31:0]        q_uid_reg, q_tty_reg, q_when_reg;
    logic [2:0]         res_status_reg, res_status_next;
    logic [63:0]        res_name_reg, res_name_next;
    sess_entry_t        rd_data_reg;
    logic               rd_en, wr_en, load_q;
    logic [IDX_W-1:0]   rd_addr;
    logic               out_free;
    logic               finish;
    logic               exact;

    assign out_free  = !res_valid_reg || m_tready;
    assign pop_ready = (state_reg == ST_IDLE) && out_free;
    assign m_tvalid  = res_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W - 67){1'b0}}, res_name_reg, res_status_reg};
    assign rd_addr   = issue_reg[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        have_next       = have_reg;
        latest_next     = latest_reg;
        guess_next      = guess_reg;
        res_valid_next  = res_valid_reg && !m_tready;
        res_status_next = res_status_reg;
        res_name_next   = res_name_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        load_q          = 1'b0;
        finish          = 1'b0;
        exact           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    res_name_next = '0;
                    case (pop_data.req)
                        REQ_LOAD:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg == CNT_W'(SESSION_DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                res_status_next = STAT_DONE;
                                wr_en           = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_QUERY:
                        begin
                            load_q      = 1'b1;
                            state_next  = ST_SCAN;
                            issue_next  = '0;
                            pend_next   = 1'b0;
                            have_next   = 1'b0;
                            latest_next = '0;
                            guess_next  = '0;
                        end
                        REQ_CLEAR:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = STAT_DONE;
                            count_next      = '0;
                        end
                        default:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (rd_data_reg.uid > q_uid_reg)
                    begin
                        finish = 1'b1;
                    end
                    else if (rd_data_reg.uid == q_uid_reg && rd_data_reg.tty == q_tty_reg
                             && q_when_reg >= rd_data_reg.start)
                    begin
                        if (q_when_reg <= rd_data_reg.fin)
                        begin
                            finish = 1'b1;
                            exact  = 1'b1;
                        end
                        else if (rd_data_reg.fin > latest_reg)
                        begin
                            latest_next = rd_data_reg.fin;
                            guess_next  = rd_data_reg.name;
                            have_next   = 1'b1;
                        end
                    end
                end
                else if (issue_reg >= count_reg)
                begin
                    finish = 1'b1;
                end
                if (!finish)
                begin
                    if (issue_reg < count_reg)
                    begin
                        rd_en      = 1'b1;
                        issue_next = issue_reg + CNT_W'(1);
                        pend_next  = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    if (exact)
                    begin
                        res_status_next = STAT_EXACT;
                        res_name_next   = rd_data_reg.name;
                    end
                    else if (have_reg)
                    begin
                        res_status_next = STAT_GUESS;
                        res_name_next   = guess_reg;
                    end
                    else
                    begin
                        res_status_next = STAT_NONE;
                        res_name_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        latest_reg     <= latest_next;
        guess_reg      <= guess_next;
        res_status_reg <= res_status_next;
        res_name_reg   <= res_name_next;
        if (load_q)
        begin
            q_uid_reg  <= pop_data.entry.uid;
            q_tty_reg  <= pop_data.entry.tty;
            q_when_reg <= pop_data.entry.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= pop_data.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/session_owner_lookup_top.sv
// Session table with owner lookup.
// Items enter on the s_ channel: tuser carries the request type (load, query,
// clear) and tdata carries the session or process fields. Every item yields
// exactly one result item on the m_ channel with a status and a login name.
// A front stage classifies each item and computes the saturated end time, a
// two-entry command queue decouples it from the back end, which owns the
// session memory and scans it for queries.
// A load or clear passes through a queue slot and the result register on its
// way to the output, and the back end retires one of them per cycle while the
// receiver takes results. A query holds the back end while the scan reads one
// memory entry per cycle through a single registered read port; it ends early
// at the first entry with a larger user id or at an exact match.
// Reset empties the table and the queue and drops any pending result. When the
// receiver stalls, the result register holds its item, the back end stops,
// and the queue fills until s_tready falls.
module session_owner_lookup_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // user_id, login_name, terminal, begin_time, connect_prime, connect_nonprime
    input  logic [sol_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [sol_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, owner_name, zero padding
    output logic [sol_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sol_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    cmd_t push_data, pop_data;

    sol_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sol_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sol_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/sol_checker.sv
module sol_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sol_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [sol_pkg::IN_USER_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sol_pkg::OUT_DATA_W-1:0] m_tdata
);
    import sol_pkg::*;

    // Only a query that found a session returns a name.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != STAT_EXACT && m_tdata[2:0] != STAT_GUESS
        |-> m_tdata[66:3] == 64'd0)
        else $error("name returned without a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:67] == '0)
        else $error("padding bits set");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result pending right after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind session_owner_lookup_top sol_checker u_sol_checker (.*);
